[design/lcvs_pkg.sv]
// lcvs_pkg: shared types for the longest consecutive-value subsequence block.
// Holds the controller state enum and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package lcvs_pkg;

    localparam int VALUE_W  = 32;
    localparam int LENGTH_W = 7;
    localparam int POS_W    = 6;

    typedef enum logic [3:0] {
        S_LOAD,
        S_INIT,
        S_START,
        S_FIRST,
        S_SCAN,
        S_END,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_HOLD
    } t_state;

    typedef struct packed {
        logic load;       // store accepted item
        logic init;       // begin search
        logic start_rd;   // read value at start position
        logic first;      // latch start value, open a new chain
        logic scan;       // compare one candidate position
        logic chain_end;  // close chain, keep it if longer
        logic out_ld;     // load output register
        logic out_take;   // output transaction completes
    } t_cmd;

    typedef struct packed {
        logic p_end;      // scan position reached item count
        logic s_end;      // current start is the last one
        logic o_last;     // output register holds final result
    } t_status;

endpackage

[design/lcvs_ram.sv]
// lcvs_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lcvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/lcvs_ctrl.sv]
// lcvs_ctrl: sequencing state machine for load, search and result output.
// Depends on lcvs_pkg (t_state, t_cmd, t_status).
`timescale 1ns / 1ps

module lcvs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_last_item,
    input  logic              i_out_ready,
    input  lcvs_pkg::t_status i_status,
    output logic              o_in_ready,
    output lcvs_pkg::t_cmd    o_cmd
);

    lcvs_pkg::t_state r_state;
    lcvs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lcvs_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            lcvs_pkg::S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_last_item) begin
                        n_state = lcvs_pkg::S_INIT;
                    end
                end
            end
            lcvs_pkg::S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = lcvs_pkg::S_START;
            end
            lcvs_pkg::S_START: begin
                o_cmd.start_rd = 1'b1;
                n_state        = lcvs_pkg::S_FIRST;
            end
            lcvs_pkg::S_FIRST: begin
                o_cmd.first = 1'b1;
                n_state     = lcvs_pkg::S_SCAN;
            end
            lcvs_pkg::S_SCAN: begin
                if (i_status.p_end) begin
                    n_state = lcvs_pkg::S_END;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            lcvs_pkg::S_END: begin
                o_cmd.chain_end = 1'b1;
                n_state = i_status.s_end ? lcvs_pkg::S_OUT_RD : lcvs_pkg::S_START;
            end
            lcvs_pkg::S_OUT_RD: begin
                // chain RAM read of position r_k is in flight
                n_state = lcvs_pkg::S_OUT_LD;
            end
            lcvs_pkg::S_OUT_LD: begin
                o_cmd.out_ld = 1'b1;
                n_state      = lcvs_pkg::S_OUT_HOLD;
            end
            lcvs_pkg::S_OUT_HOLD: begin
                if (i_out_ready) begin
                    o_cmd.out_take = 1'b1;
                    n_state = i_status.o_last ? lcvs_pkg::S_LOAD : lcvs_pkg::S_OUT_RD;
                end
            end
            default: begin
                n_state = lcvs_pkg::S_LOAD;
            end
        endcase
    end

endmodule

[design/lcvs_dp.sv]
// lcvs_dp: value store, chain stores, scan registers and output register.
// Depends on lcvs_pkg (t_cmd, t_status, widths) and lcvs_ram.
`timescale 1ns / 1ps

module lcvs_dp #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lcvs_pkg::t_cmd                 i_cmd,
    input  logic signed [lcvs_pkg::VALUE_W-1:0] i_item_value,
    output lcvs_pkg::t_status              o_status,
    output logic                           o_out_valid,
    output logic [lcvs_pkg::LENGTH_W-1:0]  o_best_length,
    output logic [lcvs_pkg::POS_W-1:0]     o_position,
    output logic                           o_last_result
);

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int VW = lcvs_pkg::VALUE_W;
    localparam int LW = lcvs_pkg::LENGTH_W;
    localparam int PW = lcvs_pkg::POS_W;
    localparam logic [VW-1:0] VALUE_MAX = {1'b0, {(VW-1){1'b1}}};

    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_s;
    logic [CW-1:0] r_p;
    logic [VW-1:0] r_cur;
    logic [CW-1:0] r_len;
    logic [CW-1:0] r_best;
    logic          r_sel;
    logic [AW-1:0] r_k;
    logic          r_o_valid;
    logic [LW-1:0] r_o_len;
    logic [PW-1:0] r_o_pos;
    logic          r_o_last;

    logic [VW-1:0] val_rdata;
    logic [AW-1:0] val_raddr;
    logic          val_we;
    logic [AW-1:0] ch_waddr;
    logic [AW-1:0] ch_wdata;
    logic          ch_we;
    logic [AW-1:0] ch0_rdata;
    logic [AW-1:0] ch1_rdata;
    logic [AW-1:0] best_rdata;
    logic [CW-1:0] s_nxt;
    logic [CW-1:0] p_nxt;
    logic [VW-1:0] cur_inc;
    logic          hit;
    logic          best_le1;
    logic          k_end;
    logic [AW+PW-1:0] pos_ext;
    logic [CW+LW-1:0] len_ext;

    assign s_nxt    = CW'(r_s) + CW'(1);
    assign p_nxt    = r_p + CW'(1);
    assign cur_inc  = r_cur + VW'(1);
    // greedy pick: the largest value has no successor
    assign hit      = (r_cur != VALUE_MAX) && (val_rdata == cur_inc);
    assign best_le1 = (r_best <= CW'(1));
    assign k_end    = ((CW'(r_k) + CW'(1)) == r_best);

    assign val_we = i_cmd.load && (r_cnt < CW'(MAX_ITEMS));

    always_comb begin
        val_raddr = p_nxt[AW-1:0];
        if (i_cmd.start_rd) begin
            val_raddr = r_s;
        end else if (i_cmd.first) begin
            val_raddr = s_nxt[AW-1:0];
        end
    end

    always_comb begin
        ch_we    = 1'b0;
        ch_waddr = r_len[AW-1:0];
        ch_wdata = r_p[AW-1:0];
        if (i_cmd.first) begin
            ch_we    = 1'b1;
            ch_waddr = '0;
            ch_wdata = r_s;
        end else if (i_cmd.scan && hit) begin
            ch_we = 1'b1;
        end
    end

    lcvs_ram #(.WIDTH(VW), .DEPTH(MAX_ITEMS)) u_value_ram (
        .i_clk  (i_clk),
        .i_we   (val_we),
        .i_waddr(r_cnt[AW-1:0]),
        .i_wdata(i_item_value),
        .i_raddr(val_raddr),
        .o_rdata(val_rdata)
    );

    // ping-pong chain stores: r_sel marks the one holding the best chain
    lcvs_ram #(.WIDTH(AW), .DEPTH(MAX_ITEMS)) u_chain0_ram (
        .i_clk  (i_clk),
        .i_we   (ch_we && r_sel),
        .i_waddr(ch_waddr),
        .i_wdata(ch_wdata),
        .i_raddr(r_k),
        .o_rdata(ch0_rdata)
    );

    lcvs_ram #(.WIDTH(AW), .DEPTH(MAX_ITEMS)) u_chain1_ram (
        .i_clk  (i_clk),
        .i_we   (ch_we && !r_sel),
        .i_waddr(ch_waddr),
        .i_wdata(ch_wdata),
        .i_raddr(r_k),
        .o_rdata(ch1_rdata)
    );

    assign best_rdata = r_sel ? ch1_rdata : ch0_rdata;
    assign pos_ext    = {{PW{1'b0}}, best_rdata};
    assign len_ext    = {{LW{1'b0}}, r_best};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_best    <= CW'(1);
            r_sel     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (val_we) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (i_cmd.init) begin
                r_best <= CW'(1);
                r_sel  <= 1'b0;
            end
            if (i_cmd.chain_end && (r_len > r_best)) begin
                r_best <= r_len;
                r_sel  <= !r_sel;
            end
            if (i_cmd.out_ld) begin
                r_o_valid <= 1'b1;
            end
            if (i_cmd.out_take) begin
                r_o_valid <= 1'b0;
                if (r_o_last) begin
                    r_cnt  <= '0;
                    r_best <= CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_s <= '0;
        end
        if (i_cmd.first) begin
            r_cur <= val_rdata;
            r_len <= CW'(1);
            r_p   <= s_nxt;
        end
        if (i_cmd.scan) begin
            r_p <= p_nxt;
            if (hit) begin
                r_cur <= val_rdata;
                r_len <= r_len + CW'(1);
            end
        end
        if (i_cmd.chain_end) begin
            r_s <= s_nxt[AW-1:0];
            r_k <= '0;
        end
        if (i_cmd.out_ld) begin
            r_o_len  <= len_ext[LW-1:0];
            r_o_pos  <= best_le1 ? '0 : pos_ext[PW-1:0];
            r_o_last <= best_le1 || k_end;
        end
        if (i_cmd.out_take) begin
            r_k <= r_k + AW'(1);
        end
    end

    assign o_status.p_end  = (r_p >= r_cnt);
    assign o_status.s_end  = (s_nxt == r_cnt);
    assign o_status.o_last = r_o_last;

    assign o_out_valid   = r_o_valid;
    assign o_best_length = r_o_len;
    assign o_position    = r_o_pos;
    assign o_last_result = r_o_last;

endmodule

[design/longest_consecutive_value_subsequence.sv]
// Longest consecutive-value subsequence finder, top level.
// Depends on lcvs_pkg, lcvs_ctrl, lcvs_dp (which uses lcvs_ram).
//
// Use:
//   Input channel (i_in_valid / o_in_ready): one signed value per
//   transaction, i_last_item marks the final value and starts the search.
//   Values past MAX_ITEMS are dropped; the count saturates.
//   Output channel (o_out_valid / i_out_ready): one transaction per chosen
//   position in ascending order, each carrying the best length; the final
//   one has o_last_result set. A best length of 1 gives one result at 0.
// Sequence, for n stored values:
//   load: one value per cycle while loading.
//   search: every start s scans s+1..n-1 through the single read port of
//   the value RAM.
//   output: one result at a time; the next is read once the last is taken.
//   No input is taken from the last item until the final result is taken.
// Reset (synchronous, active low) empties the store and idles the output.
// A stalled receiver simply holds the output register; nothing is lost.
`timescale 1ns / 1ps

module longest_consecutive_value_subsequence #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [lcvs_pkg::VALUE_W-1:0] i_item_value,
    input  logic                           i_last_item,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [lcvs_pkg::LENGTH_W-1:0]  o_best_length,
    output logic [lcvs_pkg::POS_W-1:0]     o_position,
    output logic                           o_last_result
);

    lcvs_pkg::t_cmd    cmd;
    lcvs_pkg::t_status status;

    // controller: load / scan / emit sequencing
    lcvs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last_item(i_last_item),
        .i_out_ready(i_out_ready),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // datapath: value RAM, two chain RAMs swapped on a new best, output reg
    lcvs_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_item_value (i_item_value),
        .o_status     (status),
        .o_out_valid  (o_out_valid),
        .o_best_length(o_best_length),
        .o_position   (o_position),
        .o_last_result(o_last_result)
    );

endmodule

[tb/testbench.sv]
// Testbench for longest_consecutive_value_subsequence: directed and random sequences,
// checked against a predictor that runs the greedy chain search on its own copy of the store.
// Depends on lcvs_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_ITEMS     = 64;
    localparam int VALUE_W       = lcvs_pkg::VALUE_W;
    localparam int LENGTH_W      = lcvs_pkg::LENGTH_W;
    localparam int POS_W         = lcvs_pkg::POS_W;
    localparam int RANDOM_ITEMS  = 50;
    // Longest quiet stretch of a correct run: a full 64-entry search plus the
    // receiver's long hold-off, taken several times over.
    localparam int IDLE_LIMIT    = 20000;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 100;
    localparam int MAX_PRINTS    = 40;

    localparam logic signed [VALUE_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] INT_MIN = 32'sh8000_0000;

    // receiver stall patterns
    typedef enum int {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_PERIODIC,
        READY_COIN
    } t_ready_mode;

    // value kinds for the random sequences
    typedef enum int {
        SEQ_CLUSTER,
        SEQ_RAMP,
        SEQ_NOISE
    } t_seq_kind;

    // one expected output transaction
    typedef struct packed {
        logic [LENGTH_W-1:0] length;
        logic [POS_W-1:0]    position;
        logic                last;
    } t_chain_pick;

    // DUT ports; every input has a known value from time zero
    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        i_in_valid    = 1'b0;
    logic                        o_in_ready;
    logic signed [VALUE_W-1:0]   i_item_value  = '0;
    logic                        i_last_item   = 1'b0;
    logic                        o_out_valid;
    logic                        i_out_ready   = 1'b0;
    logic [LENGTH_W-1:0]         o_best_length;
    logic [POS_W-1:0]            o_position;
    logic                        o_last_result;

    // predictor state: the values of the sequence being loaded
    logic signed [VALUE_W-1:0]   loaded_values [0:MAX_ITEMS-1];
    int unsigned                 loaded_count = 0;
    t_chain_pick                 expected_picks [$];
    t_chain_pick                 want_pick;

    int unsigned                 error_count  = 0;
    int unsigned                 random_items = 0;

    // sender burst control
    bit                          gaps_enabled = 1'b1;
    int unsigned                 burst_left   = 0;

    // receiver control; the test bumps hold_requests to ask for a long hold-off
    int unsigned                 hold_requests = 0;
    int unsigned                 hold_seen     = 0;
    int unsigned                 hold_left     = 0;
    t_ready_mode                 ready_mode    = READY_ALWAYS;
    int unsigned                 mode_left     = 0;
    int unsigned                 ready_phase   = 0;

    int unsigned                 idle_cycles   = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    longest_consecutive_value_subsequence #(
        .MAX_ITEMS(MAX_ITEMS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_item_value(i_item_value),
        .i_last_item(i_last_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_best_length(o_best_length),
        .o_position(o_position),
        .o_last_result(o_last_result)
    );

    // One line per mismatch, capped so a broken block cannot flood the log.
    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("[%0t] mismatch, %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Predictor. Stores the value (dropped once the store is full); on the last
    // item runs the greedy search: each start extends to the earliest later
    // position holding value+1, the first strictly longer chain wins.
    function automatic void load_value(input logic signed [VALUE_W-1:0] value,
                                       input logic last);
        int unsigned               best_len;
        int unsigned               len;
        int unsigned               prev;
        int unsigned               p;
        int unsigned               s;
        int unsigned               k;
        logic [POS_W-1:0]          best_pos  [0:MAX_ITEMS-1];
        logic [POS_W-1:0]          chain_pos [0:MAX_ITEMS-1];
        logic signed [VALUE_W-1:0] cur;
        bit                        found;
        t_chain_pick               pick;

        if (loaded_count < MAX_ITEMS) begin
            loaded_values[loaded_count] = value;
            loaded_count++;
        end
        if (!last)
            return;

        best_len    = 1;
        best_pos[0] = '0;
        for (s = 0; s < loaded_count; s++) begin
            len          = 1;
            prev         = s;
            cur          = loaded_values[s];
            chain_pos[0] = POS_W'(s);
            found        = 1'b1;
            // the largest value has no successor: the chain stops, no wrap
            while (cur != INT_MAX && found) begin
                found = 1'b0;
                for (p = prev + 1; p < loaded_count && !found; p++) begin
                    if (loaded_values[p] == cur + 1) begin
                        found          = 1'b1;
                        chain_pos[len] = POS_W'(p);
                        prev           = p;
                    end
                end
                if (found) begin
                    len++;
                    cur = cur + 1;
                end
            end
            if (len > best_len) begin
                best_len = len;
                for (k = 0; k < len; k++)
                    best_pos[k] = chain_pos[k];
            end
        end

        // length one gives a single transaction at position 0
        for (k = 0; k < best_len; k++) begin
            pick.length   = LENGTH_W'(best_len);
            pick.position = best_pos[k];
            pick.last     = (k + 1 == best_len);
            expected_picks.push_back(pick);
        end
        loaded_count = 0;
    endfunction

    // Offer one item and hold it until the input transaction completes. Ready is
    // looked at on the falling edge, where nothing is changing; the transaction
    // then completes at the next rising edge. Gaps fall between bursts.
    task automatic send_item(input logic signed [VALUE_W-1:0] value, input logic last);
        int unsigned gap;
        bit          taken;

        if (gaps_enabled && burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (burst_left != 0)
            burst_left--;
        i_in_valid   <= 1'b1;
        i_item_value <= value;
        i_last_item  <= last;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = o_in_ready;
            @(posedge i_clk);
        end
        load_value(value, last);
    endtask

    // Sender stops until every expected result has been taken.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_picks.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_sequence(input logic signed [VALUE_W-1:0] values [$]);
        int k;
        for (k = 0; k < values.size(); k++)
            send_item(values[k], k == values.size() - 1);
    endtask

    // ---------------- directed tests ----------------

    // single item, most negative value: length one
    task automatic test_single_item();
        send_sequence('{INT_MIN});
        wait_drained();
    endtask

    // repeated values never chain: length one at position 0
    task automatic test_equal_values();
        send_sequence('{32'sd7, 32'sd7, 32'sd7, 32'sd7});
        wait_drained();
    endtask

    // run through zero, all-ones included
    task automatic test_ascending_run();
        send_sequence('{-32'sd2, -32'sd1, 32'sd0, 32'sd1, 32'sd2});
        wait_drained();
    endtask

    // two interleaved chains; the earlier, longer one wins
    task automatic test_interleaved_chains();
        send_sequence('{32'sd5, 32'sd1, 32'sd6, 32'sd2, 32'sd7, 32'sd3, 32'sd8});
        wait_drained();
    endtask

    // greedy pick: the first 4 is taken, the duplicate is skipped
    task automatic test_greedy_duplicate();
        send_sequence('{32'sd3, 32'sd4, 32'sd4, 32'sd5});
        wait_drained();
    endtask

    // chain ends at the largest value; equal-length chains later do not win
    task automatic test_no_wrap();
        send_sequence('{INT_MAX - 1, INT_MAX, INT_MIN, INT_MIN + 1, -32'sd1, 32'sd0});
        wait_drained();
    endtask

    // Store overflow: 66 ascending values keep only the first 64 (full length,
    // all positions); then a full store whose last item is dropped but still
    // starts the search.
    task automatic test_capacity();
        int k;
        for (k = 0; k < MAX_ITEMS + 2; k++)
            send_item(VALUE_W'(k), k == MAX_ITEMS + 1);
        wait_drained();
        for (k = 0; k < MAX_ITEMS + 1; k++)
            send_item((k == MAX_ITEMS) ? INT_MAX : VALUE_W'($urandom), k == MAX_ITEMS);
        wait_drained();
    endtask

    // Long receiver hold-off: the pending result waits in the output register while the
    // sender keeps offering the next sequence, so the input stalls too.
    task automatic test_receiver_hold_off();
        int k;
        @(negedge i_clk);
        hold_requests++;
        @(posedge i_clk);
        for (k = 0; k < 12; k++)
            send_item(VALUE_W'(1000 + k), k == 11);
        for (k = 0; k < 6; k++)
            send_item(VALUE_W'(k * 2), k == 5);
        wait_drained();
    endtask

    // ---------------- random sequences ----------------

    // Mostly clustered or ramp-like content so long chains actually form; some
    // pure noise. Bases near the extremes exercise the no-wrap end and sign bit.
    task automatic test_random_sequences();
        int unsigned               seq_len;
        int unsigned               size_pick;
        int unsigned               spread;
        int unsigned               k;
        t_seq_kind                 kind;
        logic signed [VALUE_W-1:0] base;
        logic signed [VALUE_W-1:0] value;

        while (random_items < RANDOM_ITEMS) begin
            gaps_enabled = ($urandom_range(0, 3) != 0);
            size_pick    = $urandom_range(0, 31);
            if (size_pick == 0)
                seq_len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
            else if (size_pick <= 2)
                seq_len = $urandom_range(20, MAX_ITEMS);
            else
                seq_len = $urandom_range(1, 10);

            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: kind = SEQ_CLUSTER;
                5, 6, 7:       kind = SEQ_RAMP;
                default:       kind = SEQ_NOISE;
            endcase
            case ($urandom_range(0, 3))
                0:       base = VALUE_W'($urandom);
                1:       base = INT_MAX - VALUE_W'($urandom_range(0, 10));
                2:       base = INT_MIN + VALUE_W'($urandom_range(0, 4));
                default: base = VALUE_W'($urandom_range(0, 40)) - 32'sd20;
            endcase
            spread = $urandom_range(1, 8);

            for (k = 0; k < seq_len; k++) begin
                case (kind)
                    SEQ_CLUSTER: value = base + VALUE_W'($urandom_range(0, spread));
                    SEQ_RAMP:    value = base + VALUE_W'(k)
                                       + (($urandom_range(0, 3) == 0)
                                          ? VALUE_W'($urandom_range(0, 3)) : '0);
                    default:     value = VALUE_W'($urandom);
                endcase
                send_item(value, k == seq_len - 1);
                random_items++;
            end

            // now and then the sender waits out every pending result
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end
        gaps_enabled = 1'b1;
        wait_drained();
    endtask

    // ---------------- receiver ----------------

    // A long hold-off on request, otherwise a randomly chosen pattern, re-picked
    // whenever its run ends: always ready, mostly ready, periodic, coin flip.
    always @(posedge i_clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen   <= hold_requests;
            hold_left   <= LONG_HOLD;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode <= t_ready_mode'($urandom_range(0, 3));
                mode_left  <= $urandom_range(20, 120);
            end else begin
                mode_left <= mode_left - 1;
            end
            ready_phase <= ready_phase + 1;
            case (ready_mode)
                READY_ALWAYS:   i_out_ready <= 1'b1;
                READY_MOSTLY:   i_out_ready <= ($urandom_range(0, 3) != 0);
                READY_PERIODIC: i_out_ready <= ((ready_phase % 5) < 3);
                default:        i_out_ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // ---------------- result checker ----------------

    // Sampled on the falling edge: the output transaction completes at the
    // next rising edge. Each result is matched against the oldest expectation.
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_picks.size() == 0) begin
                report_mismatch("result with nothing expected, position", o_position, 0);
            end else begin
                want_pick = expected_picks.pop_front();
                if (o_best_length !== want_pick.length)
                    report_mismatch("best_length", o_best_length, want_pick.length);
                if (o_position !== want_pick.position)
                    report_mismatch("position", o_position, want_pick.position);
                if (o_last_result !== want_pick.last)
                    report_mismatch("last_result", o_last_result, want_pick.last);
            end
        end
    end

    // ---------------- watchdog ----------------

    // Counts consecutive cycles in which neither channel completes a transaction.
    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) begin
            @(negedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("** longest_consecutive_value_subsequence: FAILED **");
        $finish;
    end

    // ---------------- test sequence ----------------

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_item();
        test_equal_values();
        test_ascending_run();
        test_interleaved_chains();
        test_greedy_duplicate();
        test_no_wrap();
        test_capacity();
        test_receiver_hold_off();
        test_random_sequences();

        // anything arriving now is a spurious result
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_picks.size() != 0)
            report_mismatch("results left expected", expected_picks.size(), 0);

        if (error_count == 0)
            $display("** longest_consecutive_value_subsequence: PASSED **");
        else
            $display("** longest_consecutive_value_subsequence: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
design/lcvs_pkg.sv
design/lcvs_ram.sv
design/lcvs_ctrl.sv
design/lcvs_dp.sv
design/longest_consecutive_value_subsequence.sv
tb/testbench.sv
